// ===== hw/rtl/tbim_pkg.sv =====
// Package for the track blockage interval table.
// Holds sizes, field widths, operation and status codes, and the coordinate helper.
// No dependencies; used by track_blockage_interval_merge_core.
`timescale 1ns / 1ps

package tbim_pkg;

   localparam int MAX_INTERVALS = 32;
   localparam int COORD_BITS    = 32;
   localparam int FIELD_BITS    = 32;
   localparam int INDEX_BITS    = $clog2(MAX_INTERVALS);
   localparam int COUNT_BITS    = $clog2(MAX_INTERVALS + 1);
   localparam int ENTRY_BITS    = 2 * COORD_BITS;

   localparam int REQ_DATA_BITS  = 4 * FIELD_BITS;
   localparam int OUT_COUNT_BITS = 6;
   localparam int RSP_DATA_BITS  = 8;

   localparam logic OP_MARK  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   localparam logic DIR_HORIZONTAL = 1'b0;
   localparam logic DIR_VERTICAL   = 1'b1;

   // low bits of the field read as two's complement, sign extended when wider
   function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [FIELD_BITS-1:0] f);
      return COORD_BITS'(signed'(f));
   endfunction

endpackage

// ===== hw/rtl/track_blockage_interval_merge_core.sv =====
// Top level of the track blockage interval table: sorted disjoint intervals with merge,
// insert and query, run by a small sequencer around one table memory.
// Depends on tbim_pkg.
`timescale 1ns / 1ps

//  channel | ports                        | payload
//  --------+------------------------------+-----------------------------------------------
//  req     | req_tvalid/tready/tdata/tuser| tdata: low_x, low_y, high_x, high_y; tuser: op
//  rsp     | rsp_tvalid/tready/tdata/tuser| tdata: overlapped, interval_count; tuser: status
//  csr     | csr_valid/csr_ready/csr_data | track_direction
//
// A query or a full-table drop scans the stored intervals; a mark may go on to shift entries.
// The scan reads one entry a cycle through the single read port, then the compaction or insert
// shift moves one entry a cycle.
// Reset clears the interval count and the direction; the table memory itself is not cleared.
// A result waiting on rsp does not block the next request; the sequencer holds in its
// final state only when a second result would overwrite an untaken one.

module track_blockage_interval_merge_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tbim_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // low_x, low_y, high_x, high_y
   input  logic [0:0]                          req_tuser,  // operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tbim_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // overlapped, interval_count, pad
   output logic [0:0]                          rsp_tuser,  // status
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [0:0]                          csr_data    // track_direction
);

   localparam int IB = tbim_pkg::INDEX_BITS;
   localparam int CB = tbim_pkg::COUNT_BITS;
   localparam int WB = tbim_pkg::COORD_BITS;
   localparam int FB = tbim_pkg::FIELD_BITS;
   localparam int EB = tbim_pkg::ENTRY_BITS;
   localparam int RSP_DATA_BITS_PAD = tbim_pkg::RSP_DATA_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT_DOWN,
      ST_SHIFT_UP,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic                    dir_ff, dir_in;
   logic                    op_ff, op_in;
   logic signed [WB-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic signed [WB-1:0]    mstart_ff, mstart_in, mend_ff, mend_in;
   logic [CB-1:0]           scan_ff, scan_in;
   logic [CB-1:0]           pos_ff, pos_in;
   logic [CB-1:0]           src_ff, src_in;
   logic [CB-1:0]           count_ff, count_in;
   logic                    hit_ff, hit_in;
   logic [IB-1:0]           first_ff, first_in, last_ff, last_in, gap_ff, gap_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [IB-1:0]           pend_dst_ff, pend_dst_in;
   logic                    status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_overlap_ff, rsp_overlap_in;
   logic                    rsp_status_ff, rsp_status_in;
   logic [tbim_pkg::OUT_COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   // table memory, one entry = {start, end}
   logic [EB-1:0]           mem [tbim_pkg::MAX_INTERVALS];
   logic [EB-1:0]           rd_data_ff;
   logic [IB-1:0]           rd_addr;
   logic                    wr_en;
   logic [IB-1:0]           wr_addr;
   logic [EB-1:0]           wr_data;

   logic signed [WB-1:0]    rd_start, rd_end;
   logic signed [WB-1:0]    pa, pb;
   logic                    meets, start_below;
   logic [CB-1:0]           scan_prev;

   assign rd_start = signed'(rd_data_ff[EB-1 -: WB]);
   assign rd_end   = signed'(rd_data_ff[WB-1:0]);
   assign meets       = (lo_ff <= rd_end) && (hi_ff >= rd_start);
   assign start_below = rd_start < lo_ff;
   assign scan_prev   = scan_ff - CB'(1);

   assign pa = (dir_ff == tbim_pkg::DIR_VERTICAL) ? tbim_pkg::to_coord(req_tdata[2*FB-1 -: FB])
                                                  : tbim_pkg::to_coord(req_tdata[FB-1:0]);
   assign pb = (dir_ff == tbim_pkg::DIR_VERTICAL) ? tbim_pkg::to_coord(req_tdata[4*FB-1 -: FB])
                                                  : tbim_pkg::to_coord(req_tdata[3*FB-1 -: FB]);

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS_PAD'({rsp_count_ff, rsp_overlap_ff});
   assign rsp_tuser  = rsp_status_ff;

   always_comb begin
      state_in       = state_ff;
      dir_in         = dir_ff;
      op_in          = op_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mstart_in      = mstart_ff;
      mend_in        = mend_ff;
      scan_in        = scan_ff;
      pos_in         = pos_ff;
      src_in         = src_ff;
      count_in       = count_ff;
      hit_in         = hit_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      gap_in         = gap_ff;
      pend_valid_in  = 1'b0;
      pend_dst_in    = pend_dst_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_overlap_in = rsp_overlap_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rd_addr        = scan_ff[IB-1:0];
      wr_en          = pend_valid_ff;
      wr_addr        = pend_dst_ff;
      wr_data        = rd_data_ff;

      if (csr_valid) begin
         dir_in = csr_data[0];
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser[0];
               lo_in     = (pa <= pb) ? pa : pb;
               hi_in     = (pa <= pb) ? pb : pa;
               scan_in   = '0;
               pos_in    = '0;
               hit_in    = 1'b0;
               status_in = tbim_pkg::STATUS_DONE;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read entry scan_ff, check the entry read last cycle
            if (scan_ff != '0) begin
               if (meets) begin
                  if (!hit_ff) begin
                     first_in  = scan_prev[IB-1:0];
                     mstart_in = start_below ? rd_start : lo_ff;
                  end
                  hit_in  = 1'b1;
                  last_in = scan_prev[IB-1:0];
                  mend_in = (rd_end > hi_ff) ? rd_end : hi_ff;
               end
               if (start_below) begin
                  pos_in = pos_ff + CB'(1);
               end
            end
            if (scan_ff == count_ff) begin
               state_in = ST_DECIDE;
            end else begin
               scan_in = scan_ff + CB'(1);
            end
         end
         ST_DECIDE: begin
            if (op_ff == tbim_pkg::OP_QUERY) begin
               state_in = ST_FINISH;
            end else if (hit_ff) begin
               wr_en    = 1'b1;
               wr_addr  = first_ff;
               wr_data  = {mstart_ff, mend_ff};
               gap_in   = last_ff - first_ff;
               src_in   = CB'(last_ff) + CB'(1);
               state_in = (last_ff == first_ff) ? ST_FINISH : ST_SHIFT_DOWN;
            end else if (count_ff == CB'(tbim_pkg::MAX_INTERVALS)) begin
               status_in = tbim_pkg::STATUS_FULL;
               state_in  = ST_FINISH;
            end else begin
               src_in   = count_ff;
               state_in = ST_SHIFT_UP;
            end
         end
         ST_SHIFT_DOWN: begin
            // close the gap left by the merged entries
            if (src_ff < count_ff) begin
               rd_addr       = src_ff[IB-1:0];
               pend_valid_in = 1'b1;
               pend_dst_in   = src_ff[IB-1:0] - gap_ff;
               src_in        = src_ff + CB'(1);
            end else if (!pend_valid_ff) begin
               count_in = count_ff - CB'(gap_ff);
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT_UP: begin
            // open a slot at the insert position, top entry first
            if (src_ff > pos_ff) begin
               rd_addr       = IB'(src_ff - CB'(1));
               pend_valid_in = 1'b1;
               pend_dst_in   = src_ff[IB-1:0];
               src_in        = src_ff - CB'(1);
            end else if (!pend_valid_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff[IB-1:0];
               wr_data  = {lo_ff, hi_ff};
               count_in = count_ff + CB'(1);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_overlap_in = hit_ff;
               rsp_status_in  = status_ff;
               rsp_count_in   = tbim_pkg::OUT_COUNT_BITS'(count_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dir_ff        <= tbim_pkg::DIR_HORIZONTAL;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         dir_ff        <= dir_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff          <= op_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mstart_ff      <= mstart_in;
      mend_ff        <= mend_in;
      scan_ff        <= scan_in;
      pos_ff         <= pos_in;
      src_ff         <= src_in;
      hit_ff         <= hit_in;
      first_ff       <= first_in;
      last_ff        <= last_in;
      gap_ff         <= gap_in;
      pend_dst_ff    <= pend_dst_in;
      status_ff      <= status_in;
      rsp_overlap_ff <= rsp_overlap_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(tbim_pkg::MAX_INTERVALS))
      else $error("interval count above table size");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == tbim_pkg::STATUS_FULL) |->
         !rsp_overlap_ff && (rsp_count_ff == tbim_pkg::OUT_COUNT_BITS'(tbim_pkg::MAX_INTERVALS)))
      else $error("full-table drop with a hit or a short table");

   a_decide_port: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> !pend_valid_ff)
      else $error("write port shared with a pending shift write");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in progress");

endmodule
